FILE: sv/pdh_pkg.sv
package pdh_pkg;

   // input item modes
   localparam logic [1:0] MODE_PAIR     = 2'd0;
   localparam logic [1:0] MODE_READ     = 2'd1;
   localparam logic [1:0] MODE_READ_CLR = 2'd2;

   // configuration register indexes
   localparam int         CSR_IDX_W     = 1;
   localparam logic [0:0] CSR_RADIUS_SQ = 1'd0;
   localparam logic [0:0] CSR_BIN_SCALE = 1'd1;
   localparam int         CSR_DATA_W    = 52;

   localparam logic [51:0] RADIUS_SQ_RESET = 52'd6553600;
   localparam logic [23:0] BIN_SCALE_RESET = 24'd5120;

   // store operations
   localparam logic [1:0] OP_INC      = 2'd0;
   localparam logic [1:0] OP_READ     = 2'd1;
   localparam logic [1:0] OP_READ_CLR = 2'd2;

   localparam int              COUNT_W    = 31;
   localparam logic [30:0]     COUNT_MAX  = 31'h7FFF_FFFF;
   localparam int              ADDR_MAX_W = 20;
   localparam int              RANGE_W    = 11;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            kind;
      logic                  ok;
      logic [ADDR_MAX_W-1:0] addr;
   } op_type;

   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

FILE: sv/pdh_front.sv
module pdh_front #(
   parameter int BINS        = 256,
   parameter int MAX_COLUMNS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          mode,
   input  logic signed [23:0]  point_a_x,
   input  logic signed [23:0]  point_a_y,
   input  logic signed [23:0]  point_b_x,
   input  logic signed [23:0]  point_b_y,
   input  logic signed [15:0]  feat_a_first,
   input  logic signed [15:0]  feat_b_first,
   input  logic signed [15:0]  feat_a_second,
   input  logic signed [15:0]  feat_b_second,
   input  logic                last_column,
   input  logic [7:0]          read_row,
   input  logic [7:0]          read_col,
   input  logic [51:0]         radius_sq,
   input  logic [23:0]         bin_scale,
   output pdh_pkg::op_type     op_out
);
   import pdh_pkg::*;

   localparam int AW  = $clog2(BINS);
   localparam int CCW = $clog2(MAX_COLUMNS + 1);

   function automatic logic [23:0] sat_add(input logic [23:0] s, input logic [16:0] d);
      logic [24:0] t;
      t = 25'(s) + 25'(d);
      return t[24] ? 24'hFF_FFFF : t[23:0];
   endfunction

   function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
      logic signed [16:0] d;
      d = 17'(a) - 17'(b);
      return d[16] ? 17'(-d) : 17'(d);
   endfunction

   logic [23:0]    first_sum_ff, first_sum_in;
   logic [23:0]    second_sum_ff, second_sum_in;
   logic [CCW-1:0] col_count_ff, col_count_in;
   logic [23:0]    first_upd, second_upd;

   logic signed [24:0] dx, dy;
   logic [24:0]        adx, ady;
   logic [RANGE_W-1:0] row_ext, col_ext, row_rev;
   logic               rd_ok;
   logic               s1_valid_in;
   logic [1:0]         s1_kind_in;

   logic                  s1_valid_ff;
   logic [1:0]            s1_kind_ff;
   logic [24:0]           s1_adx_ff, s1_ady_ff;
   logic [23:0]           s1_fsum_ff, s1_ssum_ff;
   logic                  s1_ok_ff;
   logic [ADDR_MAX_W-1:0] s1_addr_ff;

   logic                  s2_valid_ff;
   logic [1:0]            s2_kind_ff;
   logic [49:0]           s2_sqx_ff, s2_sqy_ff;
   logic [47:0]           s2_pi_ff, s2_pj_ff;
   logic                  s2_ok_ff;
   logic [ADDR_MAX_W-1:0] s2_addr_ff;

   logic [50:0] dist_sq;
   logic        in_radius;
   logic [23:0] bin_i, bin_j;
   logic        bin_ok;

   // column accumulation
   always_comb begin
      first_upd     = first_sum_ff;
      second_upd    = second_sum_ff;
      first_sum_in  = first_sum_ff;
      second_sum_in = second_sum_ff;
      col_count_in  = col_count_ff;
      if (col_count_ff < CCW'(MAX_COLUMNS)) begin
         first_upd  = sat_add(first_sum_ff, abs_diff(feat_a_first, feat_b_first));
         second_upd = sat_add(second_sum_ff, abs_diff(feat_a_second, feat_b_second));
      end
      if (accept && mode == MODE_PAIR) begin
         if (last_column) begin
            first_sum_in  = '0;
            second_sum_in = '0;
            col_count_in  = '0;
         end else begin
            first_sum_in  = first_upd;
            second_sum_in = second_upd;
            if (col_count_ff < CCW'(MAX_COLUMNS)) col_count_in = col_count_ff + CCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sum_ff  <= '0;
         second_sum_ff <= '0;
         col_count_ff  <= '0;
      end else begin
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
         col_count_ff  <= col_count_in;
      end
   end

   // stage 1: distances and read address
   assign dx  = 25'(point_b_x) - 25'(point_a_x);
   assign dy  = 25'(point_b_y) - 25'(point_a_y);
   assign adx = dx[24] ? 25'(-dx) : 25'(dx);
   assign ady = dy[24] ? 25'(-dy) : 25'(dy);

   assign row_ext = RANGE_W'(read_row);
   assign col_ext = RANGE_W'(read_col);
   assign row_rev = RANGE_W'(BINS - 1) - row_ext;
   assign rd_ok   = (row_ext < RANGE_W'(BINS)) && (col_ext < RANGE_W'(BINS));

   always_comb begin
      s1_valid_in = 1'b0;
      s1_kind_in  = OP_INC;
      case (mode)
         MODE_PAIR: begin
            s1_valid_in = accept && last_column;
            s1_kind_in  = OP_INC;
         end
         MODE_READ: begin
            s1_valid_in = accept;
            s1_kind_in  = OP_READ;
         end
         MODE_READ_CLR: begin
            s1_valid_in = accept;
            s1_kind_in  = OP_READ_CLR;
         end
         default: s1_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_adx_ff  <= adx;
      s1_ady_ff  <= ady;
      s1_fsum_ff <= first_upd;
      s1_ssum_ff <= second_upd;
      s1_ok_ff   <= rd_ok;
      s1_addr_ff <= ADDR_MAX_W'({col_ext[AW-1:0], row_rev[AW-1:0]});
   end

   // stage 2: squares and bin products
   always_ff @(posedge clock) begin
      s2_kind_ff <= s1_kind_ff;
      s2_sqx_ff  <= 50'(s1_adx_ff) * 50'(s1_adx_ff);
      s2_sqy_ff  <= 50'(s1_ady_ff) * 50'(s1_ady_ff);
      s2_pi_ff   <= 48'(s1_ssum_ff) * 48'(bin_scale);
      s2_pj_ff   <= 48'(s1_fsum_ff) * 48'(bin_scale);
      s2_ok_ff   <= s1_ok_ff;
      s2_addr_ff <= s1_addr_ff;
   end

   // stage 3: radius test and bin selection
   assign dist_sq   = 51'(s2_sqx_ff) + 51'(s2_sqy_ff);
   assign in_radius = 60'(dist_sq) < {radius_sq, 8'b0};
   assign bin_i     = s2_pi_ff[47:24];
   assign bin_j     = s2_pj_ff[47:24];
   assign bin_ok    = (bin_i < 24'(BINS)) && (bin_j < 24'(BINS));

   always_comb begin
      op_out.kind = s2_kind_ff;
      if (s2_kind_ff == OP_INC) begin
         op_out.valid = s2_valid_ff && in_radius && bin_ok;
         op_out.ok    = 1'b1;
         op_out.addr  = ADDR_MAX_W'({bin_i[AW-1:0], bin_j[AW-1:0]});
      end else begin
         op_out.valid = s2_valid_ff;
         op_out.ok    = s2_ok_ff;
         op_out.addr  = s2_addr_ff;
      end
   end

endmodule

FILE: sv/pdh_store.sv
module pdh_store #(
   parameter int BINS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  pdh_pkg::op_type  op_in,
   output logic             clear_busy,
   output pdh_pkg::rsp_type rsp_out
);
   import pdh_pkg::*;

   localparam int AW    = $clog2(BINS);
   localparam int DEPTH = 1 << (2 * AW);

   logic [COUNT_W-1:0] mem [DEPTH];

   logic              clr_busy_ff;
   logic [2*AW-1:0]   clr_addr_ff;

   logic [COUNT_W-1:0] rd_data_ff;
   logic               s4_valid_ff;
   logic [1:0]         s4_kind_ff;
   logic               s4_ok_ff;
   logic [2*AW-1:0]    s4_addr_ff;

   logic               fw_valid_ff;
   logic [2*AW-1:0]    fw_addr_ff;
   logic [COUNT_W-1:0] fw_data_ff;

   logic [COUNT_W-1:0] old_count;
   logic               wr_en;
   logic [COUNT_W-1:0] wr_data;

   assign clear_busy = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {2*AW{1'b1}}) clr_busy_ff <= 1'b0;
      end
   end

   // take the previous write when it hits the entry just read
   assign old_count = (fw_valid_ff && fw_addr_ff == s4_addr_ff) ? fw_data_ff : rd_data_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_data = old_count;
      case (s4_kind_ff)
         OP_INC: begin
            wr_en   = s4_valid_ff;
            wr_data = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
         end
         OP_READ_CLR: begin
            wr_en   = s4_valid_ff && s4_ok_ff;
            wr_data = '0;
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign rsp_out.valid = s4_valid_ff && (s4_kind_ff == OP_READ || s4_kind_ff == OP_READ_CLR);
   assign rsp_out.count = s4_ok_ff ? old_count : '0;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[op_in.addr[2*AW-1:0]];
      if (clr_busy_ff) mem[clr_addr_ff] <= '0;
      else if (wr_en) mem[s4_addr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= op_in.valid;
         fw_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      s4_kind_ff <= op_in.kind;
      s4_ok_ff   <= op_in.ok;
      s4_addr_ff <= op_in.addr[2*AW-1:0];
      fw_addr_ff <= s4_addr_ff;
      fw_data_ff <= wr_data;
   end

   a_no_op_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !op_in.valid) else $error("operation during clearing pass");

   a_inc_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && s4_kind_ff == OP_INC) |-> wr_data != '0) else $error("count wrapped");

endmodule

FILE: sv/pdh_rsp_queue.sv
module pdh_rsp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  pdh_pkg::rsp_type            push,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pdh_pkg::COUNT_W-1:0] rsp_bin_count
);
   import pdh_pkg::*;

   logic [COUNT_W-1:0]    entry [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign rsp_valid     = count_ff != '0;
   assign rsp_bin_count = entry[rd_ptr_ff];
   assign pop           = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) count_in = count_ff + 1'b1;
      else if (!push.valid && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) entry[wr_ptr_ff] <= push.count;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> count_ff != FIFO_CNT_W'(FIFO_DEPTH)) else $error("queue overflow");

endmodule

FILE: sv/pair_distance_histogram.sv
// Two-dimensional histogram of L1 feature distances over sample pairs that lie
// within a radius. A pair streams in as one word per feature column (mode 0);
// the word flagged last_column closes the pair, carries both points, and, when
// the squared distance is below radius_sq * 256 and both bins fall inside the
// matrix, bumps the saturating bin (second-sum bin, first-sum bin). Modes 1
// and 2 return one bin of the transposed, row-reversed matrix, mode 2 also
// clearing it; mode 3 is ignored. One word is taken per cycle unless stalled.
// A closing word reaches the single read-modify-write port of the bin memory
// and a read result passes the store's read register into the output queue,
// with back-to-back hits on one bin forwarded. The request side stalls while
// eight read results are owed to the response side. After reset the bin memory
// is zeroed one entry a cycle, 2^(2*ceil(log2 BINS)) entries (65536 at
// BINS = 256), and no request word is taken until that pass ends; csr writes
// are taken at any time but must only be issued while the block is idle.
module pair_distance_histogram #(
   parameter int BINS        = 256,
   parameter int MAX_COLUMNS = 256
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic signed [23:0]             req_point_a_x,
   input  logic signed [23:0]             req_point_a_y,
   input  logic signed [23:0]             req_point_b_x,
   input  logic signed [23:0]             req_point_b_y,
   input  logic signed [15:0]             req_feat_a_first,
   input  logic signed [15:0]             req_feat_b_first,
   input  logic signed [15:0]             req_feat_a_second,
   input  logic signed [15:0]             req_feat_b_second,
   input  logic                           req_last_column,
   input  logic [7:0]                     req_read_row,
   input  logic [7:0]                     req_read_col,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pdh_pkg::COUNT_W-1:0]    rsp_bin_count,

   input  logic                           csr_write_en,
   input  logic [pdh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pdh_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pdh_pkg::*;

   logic [51:0] radius_sq_ff;
   logic [23:0] bin_scale_ff;

   logic                  req_accept;
   logic                  req_is_read;
   logic                  rsp_accept;
   logic [FIFO_CNT_W-1:0] credit_ff, credit_in;
   logic                  clear_busy;

   op_type  store_op;
   rsp_type store_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= RADIUS_SQ_RESET;
         bin_scale_ff <= BIN_SCALE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RADIUS_SQ: radius_sq_ff <= csr_wdata;
            CSR_BIN_SCALE: bin_scale_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Hold request words while the memory clears or while every queue slot is
   // already owed to a read in flight; feature columns never need a slot, but
   // the stall stays independent of the payload.
   assign req_stall   = clear_busy || (credit_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign req_accept  = req_valid && !req_stall;
   assign req_is_read = (req_mode == MODE_READ) || (req_mode == MODE_READ_CLR);
   assign rsp_accept  = rsp_valid && !rsp_stall;

   // count reads accepted and not yet delivered
   always_comb begin
      credit_in = credit_ff;
      if ((req_accept && req_is_read) && !rsp_accept) credit_in = credit_ff + 1'b1;
      else if (!(req_accept && req_is_read) && rsp_accept) credit_in = credit_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) credit_ff <= '0;
      else credit_ff <= credit_in;
   end

   // accumulate columns, test radius, compute bins and addresses
   pdh_front #(
      .BINS        (BINS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .mode          (req_mode),
      .point_a_x     (req_point_a_x),
      .point_a_y     (req_point_a_y),
      .point_b_x     (req_point_b_x),
      .point_b_y     (req_point_b_y),
      .feat_a_first  (req_feat_a_first),
      .feat_b_first  (req_feat_b_first),
      .feat_a_second (req_feat_a_second),
      .feat_b_second (req_feat_b_second),
      .last_column   (req_last_column),
      .read_row      (req_read_row),
      .read_col      (req_read_col),
      .radius_sq     (radius_sq_ff),
      .bin_scale     (bin_scale_ff),
      .op_out        (store_op)
   );

   // bin memory with read-modify-write and clearing pass
   pdh_store #(
      .BINS (BINS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .op_in      (store_op),
      .clear_busy (clear_busy),
      .rsp_out    (store_rsp)
   );

   // decouple results from the response side
   pdh_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (store_rsp),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin_count (rsp_bin_count)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= FIFO_CNT_W'(FIFO_DEPTH)) else $error("read credit overrun");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> credit_ff != '0) else $error("response word without a read");

endmodule
